/* hw/rtl/oledtxt_pkg.sv */
// ----------------------------------------------------------------------------
// oledtxt_pkg: shared types and constants
// Geometry, transaction codes, inter-stage structs and the 9x16 font ROM for
// the two-line text to OLED page byte streamer.
// ----------------------------------------------------------------------------
package oledtxt_pkg;

   // Geometry
   localparam int LINE_CHARS      = 14;
   localparam int DISPLAY_COLUMNS = 128;
   localparam int STORE_DEPTH     = 2 * LINE_CHARS;
   localparam int STORE_W         = $clog2(STORE_DEPTH);
   localparam int CHAR_W          = $clog2(LINE_CHARS + 1);
   localparam int COL_W           = $clog2(DISPLAY_COLUMNS);
   localparam int PAD_COLS        = 9;
   localparam int GLYPH_COLS      = 9;
   localparam int GLYPH_BYTES     = 18;
   localparam int GCOL_W          = 4;
   localparam int GBYTE_W         = 5;
   localparam int FONT_ENTRIES    = 47;
   localparam int FONT_IDX_W      = 6;

   localparam logic [7:0] FONT_FIRST = 8'h2c;
   localparam logic [7:0] FONT_END   = 8'(FONT_FIRST + FONT_ENTRIES);
   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] NUL_CODE   = 8'h00;

   // Transaction kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_WRITE = 2'd0;
   localparam kind_type KIND_START = 2'd1;
   localparam kind_type KIND_TICK  = 2'd2;

   // Page roles
   typedef logic [2:0] page_type;
   localparam page_type PAGE_LINE0_TOP = 3'd1;
   localparam page_type PAGE_LINE0_BOT = 3'd2;
   localparam page_type PAGE_LINE1_TOP = 3'd4;
   localparam page_type PAGE_LINE1_BOT = 3'd5;
   localparam page_type PAGE_LAST      = 3'd7;

   // Registered request transaction
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic       line_sel;
      logic [3:0] char_pos;
      logic [7:0] char_code;
   } item_type;

   // Sequencer to font stage
   typedef struct packed {
      logic              valid;
      logic              draw;
      logic [7:0]        code;
      logic [GCOL_W-1:0] gcol;
      logic              half;
      page_type          page;
      logic              last;
   } glyph_req_type;

   typedef logic [7:0] glyph_row_type [GLYPH_BYTES];

   // Font, first code 0x2c; bytes 0..8 upper half, 9..17 lower half
   localparam glyph_row_type FONT_ROM [FONT_ENTRIES] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'he0, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h30, 8'h0c, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'hc0, 8'h60, 8'h10, 8'h10, 8'h10, 8'h60, 8'hc0, 8'h00,
        8'h00, 8'h0f, 8'h18, 8'h20, 8'h23, 8'h20, 8'h18, 8'h07, 8'h00},
      '{8'h00, 8'h00, 8'h20, 8'h10, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h20, 8'h20, 8'h3f, 8'h20, 8'h20, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h30, 8'h10, 8'h10, 8'h30, 8'he0, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h30, 8'h28, 8'h24, 8'h23, 8'h21, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h20, 8'h10, 8'h10, 8'ha0, 8'he0, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h20, 8'h21, 8'h21, 8'h13, 8'h1e, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h80, 8'h60, 8'hf0, 8'hf0, 8'h00, 8'h00,
        8'h00, 8'h0c, 8'h0b, 8'h08, 8'h08, 8'h3f, 8'h3f, 8'h08, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h31, 8'h21, 8'h21, 8'h33, 8'h1e, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'he0, 8'h30, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h03, 8'h1f, 8'h31, 8'h21, 8'h21, 8'h1a, 8'h0c, 8'h00},
      '{8'h00, 8'h10, 8'h10, 8'h10, 8'h10, 8'h90, 8'h70, 8'h10, 8'h00,
        8'h00, 8'h00, 8'h20, 8'h38, 8'h0e, 8'h01, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'he0, 8'h10, 8'h10, 8'h10, 8'he0, 8'h00, 8'h00,
        8'h00, 8'h0c, 8'h1e, 8'h21, 8'h21, 8'h21, 8'h1e, 8'h0c, 8'h00},
      '{8'h00, 8'hc0, 8'he0, 8'h10, 8'h10, 8'h30, 8'he0, 8'h80, 8'h00,
        8'h00, 8'h00, 8'h21, 8'h22, 8'h22, 8'h32, 8'h1f, 8'h07, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h40, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h01, 8'h02, 8'h06, 8'h04, 8'h08, 8'h00, 8'h00},
      '{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
        8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00},
      '{8'h00, 8'h00, 8'h20, 8'h40, 8'h40, 8'h80, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h08, 8'h04, 8'h04, 8'h02, 8'h01, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h20, 8'h10, 8'h10, 8'hb0, 8'he0, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h36, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'hc0, 8'h20, 8'h10, 8'h90, 8'h90, 8'h20, 8'hc0, 8'h00,
        8'h00, 8'h3f, 8'h40, 8'h9b, 8'h90, 8'h9f, 8'h90, 8'h0c, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'he0, 8'h30, 8'he0, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h38, 8'h0f, 8'h05, 8'h04, 8'h05, 8'h0f, 8'h38, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'he0, 8'h40, 8'h00,
        8'h00, 8'h00, 8'h3f, 8'h21, 8'h21, 8'h21, 8'h12, 8'h0c, 8'h00},
      '{8'h00, 8'hc0, 8'h60, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h0f, 8'h18, 8'h20, 8'h20, 8'h20, 8'h20, 8'h10, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h10, 8'h10, 8'h30, 8'h60, 8'hc0, 8'h00,
        8'h00, 8'h00, 8'h3f, 8'h20, 8'h20, 8'h30, 8'h18, 8'h0f, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h3f, 8'h21, 8'h21, 8'h21, 8'h21, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h3f, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00},
      '{8'h00, 8'hc0, 8'h60, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h0f, 8'h18, 8'h20, 8'h20, 8'h22, 8'h32, 8'h1e, 8'h00},
      '{8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h3f, 8'h01, 8'h01, 8'h01, 8'h3f, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h10, 8'h10, 8'hf0, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h20, 8'h20, 8'h3f, 8'h20, 8'h20, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h1f, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'h00, 8'h80, 8'h40, 8'h20, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h3f, 8'h01, 8'h03, 8'h06, 8'h18, 8'h30, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h3f, 8'h20, 8'h20, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00},
      '{8'hf0, 8'h70, 8'hc0, 8'h00, 8'hc0, 8'h30, 8'hf0, 8'h00, 8'h00,
        8'h3f, 8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h3f, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'hc0, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h3f, 8'h00, 8'h03, 8'h0c, 8'h3f, 8'h00, 8'h00, 8'h00},
      '{8'hc0, 8'h60, 8'h10, 8'h10, 8'h10, 8'h60, 8'hc0, 8'h00, 8'h00,
        8'h0f, 8'h18, 8'h20, 8'h20, 8'h20, 8'h18, 8'h0f, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'hf0, 8'h40, 8'h00, 8'h00,
        8'h00, 8'h3f, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hc0, 8'h60, 8'h10, 8'h10, 8'h10, 8'h60, 8'hc0, 8'h00, 8'h00,
        8'h0f, 8'h18, 8'h20, 8'h20, 8'h60, 8'h98, 8'h8f, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'h10, 8'h10, 8'h10, 8'he0, 8'h40, 8'h00, 8'h00,
        8'h00, 8'h3f, 8'h01, 8'h03, 8'h07, 8'h18, 8'h30, 8'h00, 8'h00},
      '{8'h00, 8'he0, 8'h10, 8'h10, 8'h10, 8'h20, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h30, 8'h21, 8'h21, 8'h22, 8'h1e, 8'h00, 8'h00, 8'h00},
      '{8'h10, 8'h10, 8'h10, 8'hf0, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'hf0, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h1f, 8'h20, 8'h20, 8'h20, 8'h1f, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h70, 8'h00, 8'h00,
        8'h00, 8'h03, 8'h1c, 8'h30, 8'h1c, 8'h03, 8'h00, 8'h00, 8'h10},
      '{8'hf0, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'hf0, 8'h10, 8'h00,
        8'h1f, 8'h38, 8'h0f, 8'h03, 8'h0f, 8'h38, 8'h1f, 8'h00, 8'h00},
      '{8'h10, 8'h60, 8'hc0, 8'h00, 8'h80, 8'h60, 8'h10, 8'h00, 8'h00,
        8'h20, 8'h18, 8'h0c, 8'h03, 8'h06, 8'h18, 8'h30, 8'h00, 8'h00},
      '{8'h10, 8'h60, 8'hc0, 8'h00, 8'hc0, 8'h60, 8'h10, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h01, 8'h3f, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h10, 8'h10, 8'h10, 8'hd0, 8'h70, 8'h10, 8'h00, 8'h00,
        8'h20, 8'h38, 8'h2c, 8'h23, 8'h20, 8'h20, 8'h20, 8'h00, 8'h00}
   };

endpackage

/* hw/rtl/two_line_text_to_oled_page_bytes_top.sv */
// ----------------------------------------------------------------------------
// two_line_text_to_oled_page_bytes_top: two-line text to OLED page bytes
// Stores two text lines and streams an 8-page frame of 9x16 glyph bytes,
// one byte per tick transaction.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------
//  request   | req_kind req_line_sel req_char_pos      | start & !busy
//            | req_char_code                           |
//  response  | rsp_pixel_byte rsp_page_index           | rsp_valid, one cycle,
//            | rsp_frame_last                          | no back-pressure
//
// One request transaction can be taken every cycle; busy is high during reset
// and in the first cycle after it. A tick of a running frame passes three
// registers (request register, sequencer, font lookup) on its way to the
// response ports, so a frame of 1024 ticks streams out at one byte per cycle
// while ticks arrive every cycle. Reset (synchronous) empties both lines and
// stops any frame. The receiver cannot stall: a response is shown for
// exactly one cycle.
//
module two_line_text_to_oled_page_bytes_top
   import oledtxt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic       req_line_sel,
   input  logic [3:0] req_char_pos,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   output logic [7:0] rsp_pixel_byte,
   output logic [2:0] rsp_page_index,
   output logic       rsp_frame_last
);

   item_type      item_ff, item_in;
   logic          busy_ff;
   glyph_req_type glyph_req;

   // request register: the transaction enters here
   always_comb begin
      item_in.valid     = start && !busy_ff;
      item_in.kind      = req_kind;
      item_in.line_sel  = req_line_sel;
      item_in.char_pos  = req_char_pos;
      item_in.char_code = req_char_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
         busy_ff       <= 1'b1;
      end else begin
         item_ff.valid <= item_in.valid;
         busy_ff       <= 1'b0;
      end
      item_ff.kind      <= item_in.kind;
      item_ff.line_sel  <= item_in.line_sel;
      item_ff.char_pos  <= item_in.char_pos;
      item_ff.char_code <= item_in.char_code;
   end

   assign busy = busy_ff;

   // counters and text store
   oledtxt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .item      (item_ff),
      .glyph_req (glyph_req)
   );

   // font lookup and response register
   oledtxt_font u_font (
      .clock          (clock),
      .reset          (reset),
      .glyph_req      (glyph_req),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_page_index (rsp_page_index),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef SYNTHESIS
   a_last_on_page7: assert property (@(posedge clock) disable iff (reset)
      rsp_frame_last |-> rsp_valid && (rsp_page_index == PAGE_LAST))
      else $error("frame end flagged off the last page");
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(glyph_req.valid))
      else $error("response without a tick");
   a_not_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("busy outside reset recovery");
`endif

endmodule

/* hw/rtl/oledtxt_seq.sv */
// ----------------------------------------------------------------------------
// oledtxt_seq: text store and frame sequencer
// Holds both text lines, runs the page/column/character counters and issues
// one glyph request per tick of a running frame.
// ----------------------------------------------------------------------------
module oledtxt_seq
   import oledtxt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  item_type      item,
   output glyph_req_type glyph_req
);

   logic [7:0]        text_store_ff [STORE_DEPTH];
   logic              frame_active_ff, frame_active_in;
   page_type          page_count_ff, page_count_in;
   logic [COL_W-1:0]  column_count_ff, column_count_in;
   logic [CHAR_W-1:0] char_index_ff, char_index_in;
   logic [GCOL_W-1:0] glyph_column_ff, glyph_column_in;
   logic              line_ended_ff, line_ended_in;
   glyph_req_type     glyph_req_ff, glyph_req_in;

   logic               store_we, store_clr;
   logic [STORE_W-1:0] wr_addr, rd_addr;
   logic [7:0]         rd_code;
   logic               text_page, line_sel, half, char_ok, draw, tick;

   always_comb begin
      frame_active_in = frame_active_ff;
      page_count_in   = page_count_ff;
      column_count_in = column_count_ff;
      char_index_in   = char_index_ff;
      glyph_column_in = glyph_column_ff;
      line_ended_in   = line_ended_ff;
      store_we        = 1'b0;
      store_clr       = 1'b0;

      wr_addr = STORE_W'(item.char_pos)
              + (item.line_sel ? STORE_W'(LINE_CHARS) : STORE_W'(0));

      text_page = 1'b0;
      line_sel  = 1'b0;
      half      = 1'b0;
      case (page_count_ff)
         PAGE_LINE0_TOP: text_page = 1'b1;
         PAGE_LINE0_BOT: begin
            text_page = 1'b1;
            half      = 1'b1;
         end
         PAGE_LINE1_TOP: begin
            text_page = 1'b1;
            line_sel  = 1'b1;
         end
         PAGE_LINE1_BOT: begin
            text_page = 1'b1;
            line_sel  = 1'b1;
            half      = 1'b1;
         end
         default: text_page = 1'b0;
      endcase

      rd_addr = STORE_W'(char_index_ff)
              + (line_sel ? STORE_W'(LINE_CHARS) : STORE_W'(0));
      char_ok = char_index_ff < CHAR_W'(LINE_CHARS);
      rd_code = char_ok ? text_store_ff[rd_addr] : NUL_CODE;

      tick = item.valid && (item.kind == KIND_TICK) && frame_active_ff;
      draw = text_page && (column_count_ff >= COL_W'(PAD_COLS)) && !line_ended_ff
             && char_ok && (rd_code != NUL_CODE);

      glyph_req_in       = glyph_req_ff;
      glyph_req_in.valid = tick;
      glyph_req_in.draw  = draw;
      glyph_req_in.code  = rd_code;
      glyph_req_in.gcol  = glyph_column_ff;
      glyph_req_in.half  = half;
      glyph_req_in.page  = page_count_ff;
      glyph_req_in.last  = 1'b0;

      if (item.valid) begin
         case (item.kind)
            KIND_WRITE: begin
               store_we = !frame_active_ff && (item.char_pos < 4'(LINE_CHARS));
            end
            KIND_START: begin
               if (!frame_active_ff && (text_store_ff[0] != NUL_CODE)
                   && (text_store_ff[LINE_CHARS] != NUL_CODE)) begin
                  frame_active_in = 1'b1;
                  page_count_in   = '0;
                  column_count_in = '0;
                  char_index_in   = '0;
                  glyph_column_in = '0;
                  line_ended_in   = 1'b0;
               end
            end
            KIND_TICK: begin
               if (frame_active_ff) begin
                  if (text_page && (column_count_ff >= COL_W'(PAD_COLS))
                      && !line_ended_ff) begin
                     if (!draw) begin
                        line_ended_in = 1'b1;
                     end else if (glyph_column_ff == GCOL_W'(GLYPH_COLS - 1)) begin
                        glyph_column_in = '0;
                        char_index_in   = char_index_ff + CHAR_W'(1);
                     end else begin
                        glyph_column_in = glyph_column_ff + GCOL_W'(1);
                     end
                  end
                  column_count_in = column_count_ff + COL_W'(1);
                  if (column_count_ff == COL_W'(DISPLAY_COLUMNS - 1)) begin
                     column_count_in = '0;
                     char_index_in   = '0;
                     glyph_column_in = '0;
                     line_ended_in   = 1'b0;
                     page_count_in   = page_count_ff + 3'd1;
                     if (page_count_ff == PAGE_LAST) begin
                        glyph_req_in.last = 1'b1;
                        frame_active_in   = 1'b0;
                        store_clr         = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff    <= 1'b0;
         page_count_ff      <= '0;
         column_count_ff    <= '0;
         char_index_ff      <= '0;
         glyph_column_ff    <= '0;
         line_ended_ff      <= 1'b0;
         glyph_req_ff.valid <= 1'b0;
      end else begin
         frame_active_ff    <= frame_active_in;
         page_count_ff      <= page_count_in;
         column_count_ff    <= column_count_in;
         char_index_ff      <= char_index_in;
         glyph_column_ff    <= glyph_column_in;
         line_ended_ff      <= line_ended_in;
         glyph_req_ff.valid <= glyph_req_in.valid;
      end
      glyph_req_ff.draw <= glyph_req_in.draw;
      glyph_req_ff.code <= glyph_req_in.code;
      glyph_req_ff.gcol <= glyph_req_in.gcol;
      glyph_req_ff.half <= glyph_req_in.half;
      glyph_req_ff.page <= glyph_req_in.page;
      glyph_req_ff.last <= glyph_req_in.last;
   end

   // text store: cleared by reset and at frame end
   always_ff @(posedge clock) begin
      if (reset || store_clr) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            text_store_ff[i] <= NUL_CODE;
         end
      end else if (store_we) begin
         text_store_ff[wr_addr] <= item.char_code;
      end
   end

   assign glyph_req = glyph_req_ff;

`ifndef SYNTHESIS
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> (column_count_ff == '0) && (page_count_ff == '0)
                           && (char_index_ff == '0) && (glyph_column_ff == '0))
      else $error("counters not parked while idle");
   a_glyph_col_range: assert property (@(posedge clock) disable iff (reset)
      glyph_column_ff < GCOL_W'(GLYPH_COLS))
      else $error("glyph column out of range");
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      char_index_ff <= CHAR_W'(LINE_CHARS))
      else $error("character index past line end");
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (glyph_req_ff.valid && glyph_req_ff.last) |-> !frame_active_ff
                                                    && (text_store_ff[0] == NUL_CODE))
      else $error("last byte without frame end");
`endif

endmodule

/* hw/rtl/oledtxt_font.sv */
// ----------------------------------------------------------------------------
// oledtxt_font: glyph lookup and result register
// Turns a glyph request into the pixel byte and registers the response.
// ----------------------------------------------------------------------------
module oledtxt_font
   import oledtxt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  glyph_req_type glyph_req,
   output logic          rsp_valid,
   output logic [7:0]    rsp_pixel_byte,
   output logic [2:0]    rsp_page_index,
   output logic          rsp_frame_last
);

   logic                  rsp_valid_ff;
   logic [7:0]            pixel_ff, pixel_in;
   page_type              page_ff;
   logic                  last_ff;

   logic                  in_font;
   logic [FONT_IDX_W-1:0] font_idx;
   logic [GBYTE_W-1:0]    byte_sel;
   glyph_row_type         row;

   always_comb begin
      // space and codes outside the font render blank
      in_font  = (glyph_req.code >= FONT_FIRST) && (glyph_req.code < FONT_END)
                 && (glyph_req.code != SPACE_CODE);
      font_idx = in_font ? FONT_IDX_W'(glyph_req.code - FONT_FIRST) : '0;
      row      = FONT_ROM[font_idx];
      byte_sel = GBYTE_W'(glyph_req.gcol)
               + (glyph_req.half ? GBYTE_W'(GLYPH_COLS) : GBYTE_W'(0));
      pixel_in = (glyph_req.draw && in_font) ? row[byte_sel] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= glyph_req.valid;
      end
      pixel_ff <= pixel_in;
      page_ff  <= glyph_req.page;
      last_ff  <= glyph_req.last;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_page_index = page_ff;
   assign rsp_frame_last = rsp_valid_ff & last_ff;

endmodule

/* tb/tb_two_line_text_to_oled_page_bytes_top.sv */
// ----------------------------------------------------------------------------
// tb_two_line_text_to_oled_page_bytes_top: self-checking bench for the OLED
// two-line text streamer
// Drives write, start, tick and spare transactions with random sender gaps.
// A behavioural model of the text store and frame sequencer predicts every
// page byte. Each response is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_line_text_to_oled_page_bytes_top;
   import oledtxt_pkg::*;

   // Kind code with no function in the block; must be ignored.
   localparam kind_type KIND_SPARE = 2'd3;

   localparam int ITEM_BUDGET    = 1500;  // request transactions for the whole run
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 12;   // pipeline is 3 deep, plenty of margin
   localparam int MAX_REPORTS    = 10;
   localparam int LAST_PAGE      = 7;

   // One predicted response transaction
   typedef struct packed {
      logic [7:0] pixel;
      logic [2:0] page;
      logic       last;
   } page_byte_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_kind;
   logic       req_line_sel;
   logic [3:0] req_char_pos;
   logic [7:0] req_char_code;
   logic       rsp_valid;
   logic [7:0] rsp_pixel_byte;
   logic [2:0] rsp_page_index;
   logic       rsp_frame_last;

   two_line_text_to_oled_page_bytes_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_line_sel   (req_line_sel),
      .req_char_pos   (req_char_pos),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_page_index (rsp_page_index),
      .rsp_frame_last (rsp_frame_last)
   );

   // 50 MHz clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Prediction state: a private copy of the text store and frame counters.
   // --------------------------------------------------------------------------
   logic [7:0] line_text [2*LINE_CHARS];
   logic       frame_on;
   logic [2:0] page_cnt;
   int         col_cnt;
   int         chr_idx;
   int         gcol;
   logic       line_done;

   page_byte_type pending_bytes [$];
   page_byte_type want;

   int  error_count   = 0;
   int  items_sent    = 0;
   int  bytes_checked = 0;
   int  frames_done   = 0;
   int  quiet_cycles  = 0;
   bit  no_idle       = 1'b0;

   // Font bytes for one code and column. Each glyph is 18 bytes, byte 0 first:
   // bytes 0..8 are the upper half, 9..17 the lower half. Space and any code
   // outside comma..'Z' fall to the default and draw nothing.
   function automatic logic [7:0] glyph_slice(logic [7:0] code, int col, logic lower);
      logic [143:0] bits;
      case (code)
         8'h2c: bits = 144'h00_00_00_00_00_00_00_00_00_00_00_00_00_f0_00_00_00_00;
         8'h2d: bits = 144'h00_00_00_00_00_00_00_00_00_00_00_02_02_02_02_02_00_00;
         8'h2e: bits = 144'h00_00_00_00_00_00_00_00_00_00_00_00_00_30_00_00_00_00;
         8'h2f: bits = 144'h00_00_00_00_80_e0_10_00_00_00_00_30_0c_03_00_00_00_00;
         8'h30: bits = 144'h00_c0_60_10_10_10_60_c0_00_00_0f_18_20_23_20_18_07_00;
         8'h31: bits = 144'h00_00_20_10_f0_00_00_00_00_00_00_20_20_3f_20_20_00_00;
         8'h32: bits = 144'h00_00_30_10_10_30_e0_00_00_00_00_30_28_24_23_21_00_00;
         8'h33: bits = 144'h00_00_20_10_10_a0_e0_00_00_00_00_20_21_21_13_1e_00_00;
         8'h34: bits = 144'h00_00_00_80_60_f0_f0_00_00_00_0c_0b_08_08_3f_3f_08_00;
         8'h35: bits = 144'h00_00_f0_10_10_10_10_00_00_00_00_31_21_21_33_1e_00_00;
         8'h36: bits = 144'h00_00_e0_30_10_10_10_00_00_00_03_1f_31_21_21_1a_0c_00;
         8'h37: bits = 144'h00_10_10_10_10_90_70_10_00_00_00_20_38_0e_01_00_00_00;
         8'h38: bits = 144'h00_00_e0_10_10_10_e0_00_00_00_0c_1e_21_21_21_1e_0c_00;
         8'h39: bits = 144'h00_c0_e0_10_10_30_e0_80_00_00_00_21_22_22_32_1f_07_00;
         8'h3a: bits = 144'h00_00_00_00_c0_00_00_00_00_00_00_00_00_30_00_00_00_00;
         8'h3b: bits = 144'h00_00_00_00_c0_00_00_00_00_00_00_00_00_f0_00_00_00_00;
         8'h3c: bits = 144'h00_00_00_80_80_40_20_00_00_00_00_01_02_06_04_08_00_00;
         8'h3d: bits = 144'h00_80_80_80_80_80_80_80_00_00_04_04_04_04_04_04_04_00;
         8'h3e: bits = 144'h00_00_20_40_40_80_00_00_00_00_00_08_04_04_02_01_00_00;
         8'h3f: bits = 144'h00_00_20_10_10_b0_e0_00_00_00_00_00_36_03_01_00_00_00;
         8'h40: bits = 144'h00_c0_20_10_90_90_20_c0_00_00_3f_40_9b_90_9f_90_0c_00;
         8'h41: bits = 144'h00_00_00_e0_30_e0_00_00_00_00_38_0f_05_04_05_0f_38_00;
         8'h42: bits = 144'h00_00_f0_10_10_10_e0_40_00_00_00_3f_21_21_21_12_0c_00;
         8'h43: bits = 144'h00_c0_60_10_10_10_10_00_00_00_0f_18_20_20_20_20_10_00;
         8'h44: bits = 144'h00_00_f0_10_10_30_60_c0_00_00_00_3f_20_20_30_18_0f_00;
         8'h45: bits = 144'h00_00_f0_10_10_10_10_00_00_00_00_3f_21_21_21_21_00_00;
         8'h46: bits = 144'h00_00_f0_10_10_10_10_00_00_00_00_3f_01_01_01_01_00_00;
         8'h47: bits = 144'h00_c0_60_10_10_10_10_00_00_00_0f_18_20_20_22_32_1e_00;
         8'h48: bits = 144'h00_00_f0_00_00_00_f0_00_00_00_00_3f_01_01_01_3f_00_00;
         8'h49: bits = 144'h00_00_10_10_f0_10_10_00_00_00_00_20_20_3f_20_20_00_00;
         8'h4a: bits = 144'h00_00_00_00_f0_00_00_00_00_20_20_20_20_1f_00_00_00_00;
         8'h4b: bits = 144'h00_f0_00_80_40_20_10_00_00_00_3f_01_03_06_18_30_00_00;
         8'h4c: bits = 144'h00_f0_00_00_00_00_00_00_00_00_3f_20_20_20_20_00_00_00;
         8'h4d: bits = 144'hf0_70_c0_00_c0_30_f0_00_00_3f_00_00_03_01_00_3f_00_00;
         8'h4e: bits = 144'h00_f0_c0_00_00_f0_00_00_00_00_3f_00_03_0c_3f_00_00_00;
         8'h4f: bits = 144'hc0_60_10_10_10_60_c0_00_00_0f_18_20_20_20_18_0f_00_00;
         8'h50: bits = 144'h00_f0_10_10_10_f0_40_00_00_00_3f_01_01_01_00_00_00_00;
         8'h51: bits = 144'hc0_60_10_10_10_60_c0_00_00_0f_18_20_20_60_98_8f_00_00;
         8'h52: bits = 144'h00_f0_10_10_10_e0_40_00_00_00_3f_01_03_07_18_30_00_00;
         8'h53: bits = 144'h00_e0_10_10_10_20_00_00_00_00_30_21_21_22_1e_00_00_00;
         8'h54: bits = 144'h10_10_10_f0_10_10_10_00_00_00_00_00_3f_00_00_00_00_00;
         8'h55: bits = 144'h00_f0_00_00_00_f0_00_00_00_00_1f_20_20_20_1f_00_00_00;
         8'h56: bits = 144'h70_80_00_00_00_80_70_00_00_00_03_1c_30_1c_03_00_00_10;
         8'h57: bits = 144'hf0_00_00_80_00_00_f0_10_00_1f_38_0f_03_0f_38_1f_00_00;
         8'h58: bits = 144'h10_60_c0_00_80_60_10_00_00_20_18_0c_03_06_18_30_00_00;
         8'h59: bits = 144'h10_60_c0_00_c0_60_10_00_00_00_00_01_3f_01_00_00_00_00;
         8'h5a: bits = 144'h00_10_10_10_d0_70_10_00_00_20_38_2c_23_20_20_20_00_00;
         default: bits = '0;
      endcase
      return bits[143 - 8*(col + GLYPH_COLS*int'(lower)) -: 8];
   endfunction

   // Advance the private model by one accepted transaction; a tick of a
   // running frame queues the byte the block must return.
   task automatic predict_request(kind_type k, logic ls, logic [3:0] pos, logic [7:0] code);
      logic [2:0]    pg;
      logic          text_pg;
      logic          lower_half;
      int            row;
      logic [7:0]    ch;
      page_byte_type nb;
      case (k)
         KIND_WRITE: begin
            if (!frame_on && pos < LINE_CHARS)
               line_text[int'(ls)*LINE_CHARS + int'(pos)] = code;
         end
         KIND_START: begin
            if (!frame_on && line_text[0] != 8'h00 && line_text[LINE_CHARS] != 8'h00) begin
               frame_on  = 1'b1;
               page_cnt  = '0;
               col_cnt   = 0;
               chr_idx   = 0;
               gcol      = 0;
               line_done = 1'b0;
            end
         end
         KIND_TICK: begin
            if (frame_on) begin
               pg = page_cnt;
               text_pg = (pg == PAGE_LINE0_TOP || pg == PAGE_LINE0_BOT ||
                          pg == PAGE_LINE1_TOP || pg == PAGE_LINE1_BOT);
               row        = (pg >= PAGE_LINE1_TOP) ? 1 : 0;
               lower_half = (pg == PAGE_LINE0_BOT || pg == PAGE_LINE1_BOT);
               nb.pixel   = 8'h00;
               nb.page    = pg;
               nb.last    = 1'b0;
               // glyph columns start after the left margin and stop at the
               // first zero code or after a full line
               if (text_pg && col_cnt >= PAD_COLS && !line_done) begin
                  if (chr_idx >= LINE_CHARS) begin
                     line_done = 1'b1;
                  end else begin
                     ch = line_text[row*LINE_CHARS + chr_idx];
                     if (ch == 8'h00) begin
                        line_done = 1'b1;
                     end else begin
                        nb.pixel = glyph_slice(ch, gcol, lower_half);
                        gcol++;
                        if (gcol >= GLYPH_COLS) begin
                           gcol = 0;
                           chr_idx++;
                        end
                     end
                  end
               end
               col_cnt++;
               // a page is always exactly DISPLAY_COLUMNS wide
               if (col_cnt >= DISPLAY_COLUMNS) begin
                  col_cnt   = 0;
                  chr_idx   = 0;
                  gcol      = 0;
                  line_done = 1'b0;
                  if (pg == LAST_PAGE) begin
                     nb.last  = 1'b1;
                     frame_on = 1'b0;
                     page_cnt = '0;
                     foreach (line_text[i]) line_text[i] = 8'h00;
                     frames_done++;
                  end else begin
                     page_cnt = pg + 3'd1;
                  end
               end
               pending_bytes.push_back(nb);
            end
         end
         default: ;
      endcase
   endtask

   // --------------------------------------------------------------------------
   // Sender: optional random gap (none while no_idle is set), then hold start
   // high until the transaction is taken (start & !busy at an edge).
   // start is left high on return so back-to-back items need no extra edge.
   // --------------------------------------------------------------------------
   task automatic send_item(kind_type k, logic ls, logic [3:0] pos, logic [7:0] code);
      int gap;
      if ($urandom_range(0, 49) == 0)
         no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= k;
      req_line_sel  <= ls;
      req_char_pos  <= pos;
      req_char_code <= code;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      predict_request(k, ls, pos, code);
   endtask

   // Any kind, any field value: used as noise around the real sequences.
   task automatic send_stray_item();
      send_item(kind_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   // Sender holds off until every predicted byte has been returned.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   // Tick through whatever frame is running, with optional noise mixed in;
   // stops early once the run's transaction budget is spent.
   task automatic run_frame(int noise_pct);
      while (frame_on && items_sent < ITEM_BUDGET) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_stray_item();
         else
            send_item(KIND_TICK, 1'b0, 4'd0, 8'h00);
         if ($urandom_range(0, 299) == 0)
            wait_for_results();
      end
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Nothing should come back: idle ticks, refused starts, spare kind and
   // writes past the end of a line.
   task automatic test_ignored_requests();
      send_item(KIND_TICK,  1'b0, 4'd0,  8'h00);
      send_item(KIND_START, 1'b0, 4'd0,  8'h00);   // both lines empty
      send_item(KIND_SPARE, 1'b1, 4'd15, 8'hff);
      send_item(KIND_WRITE, 1'b0, 4'd0,  8'h48);
      send_item(KIND_START, 1'b0, 4'd0,  8'h00);   // second line still empty
      send_item(KIND_WRITE, 1'b1, 4'd14, 8'hff);
      send_item(KIND_WRITE, 1'b1, 4'd15, 8'h41);
      send_item(KIND_START, 1'b1, 4'd0,  8'h00);   // still refused
      send_item(KIND_TICK,  1'b1, 4'd0,  8'h00);
      wait_for_results();
   endtask

   // One full frame with hand-picked text: a full first line (no terminator,
   // last glyph cut at the right edge) holding both ends of the font, space
   // and codes just outside the font; a one-letter second line with junk
   // after its terminator. Traffic during the frame must be ignored.
   task automatic test_directed_frame();
      logic [7:0] full_line [LINE_CHARS] = '{8'h2c, 8'h5a, 8'h20, 8'h2b, 8'h5b, 8'hff,
                                             8'h01, 8'h41, 8'h57, 8'h80, 8'h30, 8'h7f,
                                             8'h56, 8'h40};
      for (int i = 0; i < LINE_CHARS; i++)
         send_item(KIND_WRITE, 1'b0, 4'(i), full_line[i]);
      send_item(KIND_WRITE, 1'b1, 4'd0,  8'h41);
      send_item(KIND_WRITE, 1'b1, 4'd1,  8'h00);
      send_item(KIND_WRITE, 1'b1, 4'd2,  8'h57);
      send_item(KIND_WRITE, 1'b1, 4'd13, 8'h5a);
      send_item(KIND_START, 1'b0, 4'd0,  8'h00);
      send_item(KIND_WRITE, 1'b0, 4'd0,  8'h00);   // write in a frame: dropped
      send_item(KIND_START, 1'b0, 4'd0,  8'h00);   // start in a frame: dropped
      send_item(KIND_SPARE, 1'b0, 4'd0,  8'h00);
      run_frame(0);
      // store is wiped by the last byte, so a fresh start is refused
      send_item(KIND_START, 1'b0, 4'd0,  8'h00);
      send_item(KIND_TICK,  1'b0, 4'd0,  8'h00);
      wait_for_results();
   endtask

   // Random text of random length per line, written in order with noise
   // between writes, then a frame ticked out with noise between ticks, until
   // the transaction budget is spent.
   task automatic test_random_frames();
      int         len;
      logic [7:0] code;
      while (items_sent < ITEM_BUDGET) begin
         for (int ln = 0; ln < 2; ln++) begin
            len = ($urandom_range(0, 3) == 0) ? LINE_CHARS : $urandom_range(1, LINE_CHARS - 1);
            for (int p = 0; p < LINE_CHARS; p++) begin
               if ($urandom_range(0, 11) == 0)
                  send_stray_item();
               if (p == len) begin
                  code = 8'h00;
               end else if (p > len) begin
                  code = 8'($urandom_range(0, 255));     // hidden behind terminator
               end else begin
                  case ($urandom_range(0, 9))
                     0:       code = 8'h20;
                     1, 2:    code = 8'($urandom_range(1, 255));
                     default: code = 8'($urandom_range(8'h2c, 8'h5a));
                  endcase
               end
               send_item(KIND_WRITE, 1'(ln), 4'(p), code);
            end
         end
         send_item(KIND_START, 1'b0, 4'd0, 8'h00);
         run_frame(5);
         wait_for_results();
      end
   endtask

   // --------------------------------------------------------------------------
   // Response checker: every strobe is matched against the oldest prediction.
   // Outputs are sampled at the edge that accepts them.
   // --------------------------------------------------------------------------
   task automatic log_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            log_error($sformatf("unexpected byte px=%02h page=%0d last=%0b",
                                rsp_pixel_byte, rsp_page_index, rsp_frame_last));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_pixel_byte !== want.pixel || rsp_page_index !== want.page ||
                rsp_frame_last !== want.last)
               log_error($sformatf("byte %0d: expected px=%02h page=%0d last=%0b, got px=%02h page=%0d last=%0b",
                                   bytes_checked, want.pixel, want.page, want.last,
                                   rsp_pixel_byte, rsp_page_index, rsp_frame_last));
            bytes_checked++;
         end
      end
   end

   // Watchdog: too long with neither a request nor a response taken.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_two_line_text_to_oled_page_bytes_top: errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      foreach (line_text[i]) line_text[i] = 8'h00;
      frame_on  = 1'b0;
      page_cnt  = '0;
      col_cnt   = 0;
      chr_idx   = 0;
      gcol      = 0;
      line_done = 1'b0;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_kind      <= KIND_WRITE;
      req_line_sel  <= 1'b0;
      req_char_pos  <= 4'd0;
      req_char_code <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_ignored_requests();
      test_directed_frame();
      test_random_frames();

      // drain, then allow a few more cycles for any stray late byte
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests taken, %0d frames streamed, %0d bytes checked",
               items_sent, frames_done, bytes_checked);
      $display("run: %0d predictions outstanding, %0d errors",
               pending_bytes.size(), error_count);
      if (error_count == 0 && pending_bytes.size() == 0)
         $display("tb_two_line_text_to_oled_page_bytes_top: clean");
      else
         $display("tb_two_line_text_to_oled_page_bytes_top: errors");
      $finish;
   end

endmodule

/* two_line_text_to_oled_page_bytes_top.f */
hw/rtl/oledtxt_pkg.sv
hw/rtl/oledtxt_seq.sv
hw/rtl/oledtxt_font.sv
hw/rtl/two_line_text_to_oled_page_bytes_top.sv
tb/tb_two_line_text_to_oled_page_bytes_top.sv
